// ----- src/mbv_pkg.sv -----
`default_nettype none

package mbv_pkg;

   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned CMD_W           = 3;
   localparam int unsigned COUNT_W         = 6;
   localparam int unsigned REPLY_DEPTH_DEF = 33;
   localparam int unsigned BILL_TYPES      = 5;
   localparam int unsigned CSR_COUNT       = 6;
   localparam int unsigned CSR_INDEX_W     = $clog2(CSR_COUNT);
   localparam int unsigned RSP_QUEUE_DEPTH = 4;

   localparam logic [CMD_W-1:0] CMD_ADDR   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DATA   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FINISH = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RX     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BILL_0  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BILL_1  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BILL_2  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BILL_3  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BILL_4  = 3'd5;

   localparam logic [BYTE_W-1:0] TIMEOUT_RST = 8'd5;
   localparam logic [BYTE_W-1:0] BILL_0_RST  = 8'd10;
   localparam logic [BYTE_W-1:0] BILL_1_RST  = 8'd20;
   localparam logic [BYTE_W-1:0] BILL_2_RST  = 8'd50;
   localparam logic [BYTE_W-1:0] BILL_3_RST  = 8'd100;
   localparam logic [BYTE_W-1:0] BILL_4_RST  = 8'd200;

   localparam logic [BYTE_W-1:0] BYTE_NONE    = 8'hFF;
   localparam logic [BYTE_W-1:0] ACK_BYTE     = 8'h00;
   localparam logic [BYTE_W-1:0] UNKNOWN_BILL = 8'h10;
   localparam logic [BYTE_W-1:0] STATUS_OK    = 8'h00;
   localparam logic [BYTE_W-1:0] STATUS_BUSY  = 8'h03;
   localparam logic [BYTE_W-1:0] STATUS_MAX   = 8'h0C;
   localparam logic [BYTE_W-1:0] TICK_MAX     = 8'hFF;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] byte_value;
      logic              rx_mode_bit;
   } req_item_type;

   typedef struct packed {
      logic               kind;
      logic [BYTE_W-1:0]  tx_byte;
      logic               tx_mode_bit;
      logic               timed_out;
      logic [COUNT_W-1:0] reply_count;
      logic [BYTE_W-1:0]  first_reply;
      logic [BYTE_W-1:0]  last_reply;
      logic [BYTE_W-1:0]  poll_value;
      logic               note_error;
      logic               last;
   } rsp_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]                 timeout_ticks;
      logic [BILL_TYPES-1:0][BYTE_W-1:0] bill_value;
   } cfg_type;

   typedef struct packed {
      logic [1:0]   push_count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

endpackage

`default_nettype wire

// ----- src/mbv_channels.sv -----
`default_nettype none

interface mbv_req_if;
   logic                 valid;
   logic                 ready;
   mbv_pkg::req_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mbv_rsp_if;
   logic                 valid;
   logic                 ready;
   mbv_pkg::rsp_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- src/mdb_bill_validator_transaction.sv -----
// master side of one nine-bit bus transaction with a bill validator
// req_ch: input beats; cmd selects send address, send data, finish, received
//   byte or tick; byte_value and rx_mode_bit carry the bus word
// rsp_ch: result beats; kind 0 is a word to transmit, kind 1 a finished
//   transaction with reply count, first and last reply byte and poll decode
// csr_*: write-only registers, timeout_ticks then bill_value_0..4
// path: a taken beat is first registered in the engine; its result is
//   written into the result queue, which drives rsp_ch
// throughput: one request beat per cycle, and one result beat per cycle while
//   rsp_ch.ready is high; a reply end that needs an ack gives two result beats
//   in a four-entry queue; the engine takes a held beat only while the queue
//   has room for two results, so a stalled receiver backs up into req_ch.ready
// reset: returns to idle, empties the queue, loads register defaults and
//   clears the sticky error flag
`default_nettype none

module mdb_bill_validator_transaction #(
   parameter int unsigned REPLY_DEPTH = mbv_pkg::REPLY_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   mbv_req_if.sink                               req_ch,
   mbv_rsp_if.source                             rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [mbv_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [mbv_pkg::BYTE_W-1:0]       csr_wdata
);

   mbv_pkg::cfg_type  cfg;
   mbv_pkg::push_type push;
   logic              space_ok;
   logic              in_ready;

   assign req_ch.ready = in_ready;

   mbv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mbv_engine #(
      .REPLY_DEPTH (REPLY_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_ch.valid && in_ready),
      .in_item   (req_ch.payload),
      .space_ok  (space_ok),
      .cfg       (cfg),
      .in_ready  (in_ready),
      .push      (push)
   );

   mbv_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- src/mbv_csr.sv -----
`default_nettype none

module mbv_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [mbv_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [mbv_pkg::BYTE_W-1:0]         csr_wdata,
   output mbv_pkg::cfg_type                        cfg
);

   mbv_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= mbv_pkg::TIMEOUT_RST;
         cfg_ff.bill_value[0] <= mbv_pkg::BILL_0_RST;
         cfg_ff.bill_value[1] <= mbv_pkg::BILL_1_RST;
         cfg_ff.bill_value[2] <= mbv_pkg::BILL_2_RST;
         cfg_ff.bill_value[3] <= mbv_pkg::BILL_3_RST;
         cfg_ff.bill_value[4] <= mbv_pkg::BILL_4_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            mbv_pkg::CSR_TIMEOUT: cfg_ff.timeout_ticks <= csr_wdata;
            mbv_pkg::CSR_BILL_0:  cfg_ff.bill_value[0] <= csr_wdata;
            mbv_pkg::CSR_BILL_1:  cfg_ff.bill_value[1] <= csr_wdata;
            mbv_pkg::CSR_BILL_2:  cfg_ff.bill_value[2] <= csr_wdata;
            mbv_pkg::CSR_BILL_3:  cfg_ff.bill_value[3] <= csr_wdata;
            mbv_pkg::CSR_BILL_4:  cfg_ff.bill_value[4] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- src/mbv_engine.sv -----
`default_nettype none

module mbv_engine #(
   parameter int unsigned REPLY_DEPTH = mbv_pkg::REPLY_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_accept,
   input  wire mbv_pkg::req_item_type in_item,
   input  wire logic                  space_ok,
   input  wire mbv_pkg::cfg_type      cfg,
   output logic                       in_ready,
   output mbv_pkg::push_type          push
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SEND,
      PH_RECV
   } phase_type;

   typedef struct packed {
      logic                       err;
      logic [mbv_pkg::BYTE_W-1:0] value;
   } poll_type;

   localparam logic [mbv_pkg::COUNT_W-1:0] DEPTH_CNT = mbv_pkg::COUNT_W'(REPLY_DEPTH);

   logic                        item_vld_ff;
   mbv_pkg::req_item_type       item_ff;
   phase_type                   phase_ff, phase_in;
   logic [mbv_pkg::BYTE_W-1:0]  sum_ff, sum_in;
   logic [mbv_pkg::BYTE_W-1:0]  tick_ff, tick_in;
   logic [mbv_pkg::COUNT_W-1:0] rx_ff, rx_in;
   logic [mbv_pkg::BYTE_W-1:0]  first_ff, first_in;
   logic [mbv_pkg::BYTE_W-1:0]  last_ff, last_in;
   logic                        err_ff, err_in;

   logic                        fire;
   logic [mbv_pkg::BYTE_W-1:0]  b;
   logic [mbv_pkg::BYTE_W-1:0]  rx_first;
   logic [mbv_pkg::COUNT_W-1:0] rx_next;
   logic [mbv_pkg::BYTE_W-1:0]  tick_next;
   logic                        is_rx;
   logic [mbv_pkg::BYTE_W-1:0]  done_first;
   poll_type                    poll;
   mbv_pkg::rsp_item_type       done_res;

   function automatic poll_type decode_poll(
      input logic [mbv_pkg::BYTE_W-1:0] fb,
      input mbv_pkg::cfg_type           c,
      input logic                       err
   );
      poll_type p;
      p.err   = err;
      p.value = '0;
      if (fb[7]) begin
         if (fb[6:0] < 7'(mbv_pkg::BILL_TYPES)) begin
            p.value = c.bill_value[fb[2:0]];
         end else begin
            p.value = mbv_pkg::UNKNOWN_BILL;
            p.err   = 1'b1;
         end
      end else if (fb == mbv_pkg::STATUS_OK) begin
         p.value = '0;
      end else if (fb == mbv_pkg::STATUS_BUSY) begin
         p.err = 1'b0;
      end else if (fb <= mbv_pkg::STATUS_MAX) begin
         p.value = fb;
         p.err   = 1'b1;
      end else begin
         p.err = 1'b1;
      end
      return p;
   endfunction

   function automatic mbv_pkg::rsp_item_type word_res(
      input logic [mbv_pkg::BYTE_W-1:0] wb,
      input logic                       mode,
      input logic                       fin
   );
      mbv_pkg::rsp_item_type r;
      r             = '0;
      r.tx_byte     = wb;
      r.tx_mode_bit = mode;
      r.last        = fin;
      return r;
   endfunction

   assign fire     = item_vld_ff && space_ok;
   assign in_ready = !item_vld_ff || space_ok;
   assign b        = item_ff.byte_value;

   // reply and tick updates; the reply updates are shared by the done result
   assign is_rx      = (item_ff.cmd == mbv_pkg::CMD_RX);
   assign rx_first   = (rx_ff == '0) ? b : first_ff;
   assign rx_next    = (rx_ff < DEPTH_CNT) ? rx_ff + 1'b1 : rx_ff;
   assign tick_next  = (tick_ff < mbv_pkg::TICK_MAX) ? tick_ff + 1'b1 : tick_ff;
   assign done_first = is_rx ? rx_first : first_ff;
   assign poll       = decode_poll(done_first, cfg, err_ff);

   always_comb begin
      done_res             = '0;
      done_res.kind        = 1'b1;
      done_res.timed_out   = !is_rx;
      done_res.reply_count = is_rx ? rx_next : rx_ff;
      done_res.first_reply = done_first;
      done_res.last_reply  = is_rx ? b : last_ff;
      done_res.poll_value  = poll.value;
      done_res.note_error  = poll.err;
      done_res.last        = 1'b1;
   end

   always_comb begin
      phase_in = phase_ff;
      sum_in   = sum_ff;
      tick_in  = tick_ff;
      rx_in    = rx_ff;
      first_in = first_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      push     = '0;
      if (fire) begin
         unique case (item_ff.cmd)
            mbv_pkg::CMD_ADDR: begin
               phase_in        = PH_SEND;
               sum_in          = b;
               push.push_count = 2'd1;
               push.first      = word_res(b, 1'b1, 1'b1);
            end
            mbv_pkg::CMD_DATA: begin
               if (phase_ff == PH_SEND) begin
                  sum_in          = sum_ff + b;
                  push.push_count = 2'd1;
                  push.first      = word_res(b, 1'b0, 1'b1);
               end
            end
            mbv_pkg::CMD_FINISH: begin
               if (phase_ff == PH_SEND) begin
                  phase_in        = PH_RECV;
                  tick_in         = '0;
                  rx_in           = '0;
                  first_in        = mbv_pkg::BYTE_NONE;
                  last_in         = mbv_pkg::BYTE_NONE;
                  push.push_count = 2'd1;
                  push.first      = word_res(sum_ff, 1'b0, 1'b1);
               end
            end
            mbv_pkg::CMD_RX: begin
               if (phase_ff == PH_RECV) begin
                  first_in = rx_first;
                  last_in  = b;
                  rx_in    = rx_next;
                  tick_in  = '0;
                  if (item_ff.rx_mode_bit) begin
                     phase_in = PH_IDLE;
                     err_in   = poll.err;
                     if (b != mbv_pkg::ACK_BYTE) begin
                        push.push_count = 2'd2;
                        push.first      = word_res(mbv_pkg::ACK_BYTE, 1'b1, 1'b0);
                        push.second     = done_res;
                     end else begin
                        push.push_count = 2'd1;
                        push.first      = done_res;
                     end
                  end
               end
            end
            mbv_pkg::CMD_TICK: begin
               if (phase_ff == PH_RECV) begin
                  tick_in = tick_next;
                  if (tick_next >= cfg.timeout_ticks) begin
                     phase_in        = PH_IDLE;
                     err_in          = poll.err;
                     push.push_count = 2'd1;
                     push.first      = done_res;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         phase_ff    <= PH_IDLE;
         sum_ff      <= '0;
         tick_ff     <= '0;
         rx_ff       <= '0;
         first_ff    <= mbv_pkg::BYTE_NONE;
         last_ff     <= mbv_pkg::BYTE_NONE;
         err_ff      <= 1'b0;
      end else begin
         if (in_ready) begin
            item_vld_ff <= in_accept;
         end
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         tick_ff  <= tick_in;
         rx_ff    <= rx_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

// ----- src/mbv_rsp_queue.sv -----
`default_nettype none

module mbv_rsp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mbv_pkg::push_type push,
   output logic                   space_ok,
   mbv_rsp_if.source              rsp_ch
);

   localparam int unsigned DEPTH = mbv_pkg::RSP_QUEUE_DEPTH;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   mbv_pkg::rsp_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ff, wr_in;
   logic [PTR_W-1:0]      rd_ff, rd_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  pop;
   logic [PTR_W-1:0]      wr_next;

   assign space_ok       = (cnt_ff <= CNT_W'(DEPTH - 2));
   assign rsp_ch.valid   = (cnt_ff != '0);
   assign rsp_ch.payload = entry_ff[rd_ff];
   assign pop            = rsp_ch.valid && rsp_ch.ready;
   assign wr_next        = wr_ff + 1'b1;

   always_comb begin
      wr_in  = wr_ff + PTR_W'(push.push_count);
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push.push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push_count != 2'd0) begin
         entry_ff[wr_ff] <= push.first;
      end
      if (push.push_count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

`default_nettype wire

// ----- src/mbv_checker.sv -----
`default_nettype none

module mbv_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire mbv_pkg::rsp_item_type  rsp_payload
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // only the ack word comes ahead of another result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |->
         !rsp_payload.kind && rsp_payload.tx_mode_bit &&
         rsp_payload.tx_byte == mbv_pkg::ACK_BYTE)
      else $error("non-final beat is not an ack word");

   // an ack word is always followed by its done beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last |=>
         rsp_valid && rsp_payload.kind)
      else $error("ack word not followed by done beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind |->
         rsp_payload.last && rsp_payload.tx_byte == '0 && !rsp_payload.tx_mode_bit)
      else $error("done beat carries word fields");

endmodule

bind mdb_bill_validator_transaction mbv_checker u_mbv_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

`default_nettype wire
